FILE: src/bpmq_pkg.sv
// ---------------------------------------------------------------------------
// bpmq_pkg
// Shared types, widths and helpers for the bounded priority message queue.
// ---------------------------------------------------------------------------
`default_nettype none

package bpmq_pkg;

  // default number of entries in the store
  localparam int QUEUE_DEPTH_DEF = 16;

  // item field widths
  localparam int OP_W    = 2;
  localparam int PRI_W   = 8;
  localparam int TIME_W  = 32;
  localparam int PAY_W   = 32;
  localparam int COUNT_W = 5;
  localparam int ENTRY_W = PRI_W + TIME_W + PAY_W;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 2'd0,
    OP_PUSH_OVER = 2'd1,
    OP_POP       = 2'd2,
    OP_PEEK      = 2'd3
  } op_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;       // capture the accepted item, clear the result
    logic wr_fill;     // write new entry at the fill position, count up
    logic scan_start;  // rewind the scan index
    logic scan_step;   // read one entry and advance the scan index
    logic wr_best;     // overwrite the selected entry with the new entry
    logic rd_last;     // read the last stored entry
    logic move;        // move the last entry into the selected slot, count down
    logic set_ok;
    logic set_rep;
    logic set_data;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic scan_last;
  } dp_stat_t;

  // true when entry a orders below entry b
  function automatic logic entry_less(input logic [PRI_W-1:0]  a_pri,
                                      input logic [TIME_W-1:0] a_time,
                                      input logic [PRI_W-1:0]  b_pri,
                                      input logic [TIME_W-1:0] b_time);
    logic res;
    if (a_pri != b_pri) begin
      res = (a_pri < b_pri);
    end else begin
      res = (a_time < b_time);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/bounded_priority_message_queue.sv
// Sequencing: push and non-full push-over strobe straight from decode; peek, pop and
// full push-over scan each entry (one RAM read per entry); pop refills the hole.
// Handshake: busy drops the cycle after the strobe, so a new item is accepted only
// once the last is through; a pop runs longest, bounded by the linear scan.
// Reset: synchronous active-low rst_n empties the store by clearing the fill count;
// no clearing pass. Results are one-cycle strobes and the receiver cannot stall.
// ---------------------------------------------------------------------------
// bounded_priority_message_queue
// Unsorted bounded store with push, push-over, pop-greatest and peek-greatest.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_priority_message_queue #(
  parameter int QUEUE_DEPTH = bpmq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bpmq_pkg::OP_W-1:0]     in_op,
  input  wire logic [bpmq_pkg::PRI_W-1:0]    in_new_priority,
  input  wire logic [bpmq_pkg::TIME_W-1:0]   in_new_time,
  input  wire logic [bpmq_pkg::PAY_W-1:0]    in_new_payload,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic                               out_replaced,
  output logic      [bpmq_pkg::PRI_W-1:0]    out_priority,
  output logic      [bpmq_pkg::TIME_W-1:0]   out_time,
  output logic      [bpmq_pkg::PAY_W-1:0]    out_payload,
  output logic      [bpmq_pkg::COUNT_W-1:0]  out_count
);

  import bpmq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bpmq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .stat  (stat),
    .cmd   (cmd)
  );

  // store and scan datapath
  bpmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_new_priority (in_new_priority),
    .in_new_time     (in_new_time),
    .in_new_payload  (in_new_payload),
    .res_ok          (out_ok),
    .res_replaced    (out_replaced),
    .res_priority    (out_priority),
    .res_time        (out_time),
    .res_payload     (out_payload),
    .res_count       (out_count)
  );

endmodule

`default_nettype wire

FILE: src/bpmq_ram.sv
// ---------------------------------------------------------------------------
// bpmq_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bpmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/bpmq_ctrl.sv
// ---------------------------------------------------------------------------
// bpmq_ctrl
// Sequencer for the queue: decodes the item and steps the datapath through
// append, scan, overwrite and move phases.
// ---------------------------------------------------------------------------
`default_nettype none

module bpmq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  input  wire bpmq_pkg::dp_stat_t stat,
  output bpmq_pkg::dp_cmd_t       cmd
);

  import bpmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_MOVE,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, done_r;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.op)
          OP_PUSH: begin
            if (!stat.full) begin
              cmd.wr_fill = 1'b1;
              cmd.set_ok  = 1'b1;
            end
            state_nxt = S_RESP;
          end
          OP_PUSH_OVER: begin
            cmd.set_ok = 1'b1;
            if (stat.full) begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end else begin
              cmd.wr_fill = 1'b1;
              state_nxt   = S_RESP;
            end
          end
          default: begin
            if (stat.empty) begin
              state_nxt = S_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        case (stat.op)
          OP_PUSH_OVER: begin
            cmd.wr_best = 1'b1;
            cmd.set_rep = 1'b1;
            state_nxt   = S_RESP;
          end
          OP_POP: begin
            cmd.set_ok   = 1'b1;
            cmd.set_data = 1'b1;
            cmd.rd_last  = 1'b1;
            state_nxt    = S_MOVE;
          end
          default: begin
            cmd.set_ok   = 1'b1;
            cmd.set_data = 1'b1;
            state_nxt    = S_RESP;
          end
        endcase
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      done_r  <= (state_nxt == S_RESP);
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: src/bpmq_dp.sv
// ---------------------------------------------------------------------------
// bpmq_dp
// Queue datapath: entry RAM, fill count, scan index with running best
// entry, and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module bpmq_dp #(
  parameter int QUEUE_DEPTH = bpmq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bpmq_pkg::dp_cmd_t             cmd,
  output bpmq_pkg::dp_stat_t                 stat,
  input  wire logic [bpmq_pkg::OP_W-1:0]     in_op,
  input  wire logic [bpmq_pkg::PRI_W-1:0]    in_new_priority,
  input  wire logic [bpmq_pkg::TIME_W-1:0]   in_new_time,
  input  wire logic [bpmq_pkg::PAY_W-1:0]    in_new_payload,
  output logic                               res_ok,
  output logic                               res_replaced,
  output logic      [bpmq_pkg::PRI_W-1:0]    res_priority,
  output logic      [bpmq_pkg::TIME_W-1:0]   res_time,
  output logic      [bpmq_pkg::PAY_W-1:0]    res_payload,
  output logic      [bpmq_pkg::COUNT_W-1:0]  res_count
);

  import bpmq_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = (FW > COUNT_W) ? FW : COUNT_W;
  localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

  // captured item
  op_t              op_r;
  logic [ENTRY_W-1:0] new_entry_r;

  // store state
  logic [FW-1:0]    fill_r;
  logic [FW-1:0]    last_f;
  logic [IW-1:0]    last_idx;

  // scan state
  logic [IW-1:0]    scan_idx_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  logic [IW-1:0]    best_idx_r;
  logic [PRI_W-1:0]  best_pri_r;
  logic [TIME_W-1:0] best_time_r;
  logic [PAY_W-1:0]  best_pay_r;

  // result registers
  logic             ok_r, rep_r, data_r;

  // ram ports
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [PRI_W-1:0]   rd_pri;
  logic [TIME_W-1:0]  rd_time;
  logic [PAY_W-1:0]   rd_pay;
  logic               take;
  logic [XW-1:0]      fill_ext;

  assign last_f   = fill_r - FW'(1);
  assign last_idx = last_f[IW-1:0];

  assign rd_pri  = ram_rdata[ENTRY_W-1 -: PRI_W];
  assign rd_time = ram_rdata[PAY_W +: TIME_W];
  assign rd_pay  = ram_rdata[PAY_W-1:0];

  // status to the controller
  assign stat.op        = op_r;
  assign stat.full      = (fill_r == DEPTH_F);
  assign stat.empty     = (fill_r == '0);
  assign stat.scan_last = (FW'(scan_idx_r) == last_f);

  // ram port selection
  always_comb begin
    ram_we    = cmd.wr_fill | cmd.wr_best | cmd.move;
    ram_waddr = cmd.wr_fill ? fill_r[IW-1:0] : best_idx_r;
    ram_wdata = cmd.move ? ram_rdata : new_entry_r;
    ram_re    = cmd.scan_step | cmd.rd_last;
    ram_raddr = cmd.scan_step ? scan_idx_r : last_idx;
  end

  bpmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // compare the entry read last cycle against the running best
  // strict order keeps the lowest index on exact ties
  always_comb begin
    if (rd_idx_r == '0) begin
      take = 1'b1;
    end else if (op_r == OP_PUSH_OVER) begin
      take = entry_less(rd_pri, rd_time, best_pri_r, best_time_r);
    end else begin
      take = entry_less(best_pri_r, best_time_r, rd_pri, rd_time);
    end
  end

  // item capture and scan payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r        <= op_t'(in_op);
      new_entry_r <= {in_new_priority, in_new_time, in_new_payload};
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
    rd_idx_r <= scan_idx_r;
    if (rd_vld_r && take) begin
      best_idx_r  <= rd_idx_r;
      best_pri_r  <= rd_pri;
      best_time_r <= rd_time;
      best_pay_r  <= rd_pay;
    end
  end

  // control state: fill count, read valid, result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_vld_r <= 1'b0;
      ok_r     <= 1'b0;
      rep_r    <= 1'b0;
      data_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;
      if (cmd.wr_fill) begin
        fill_r <= fill_r + FW'(1);
      end else if (cmd.move) begin
        fill_r <= last_f;
      end
      if (cmd.latch) begin
        ok_r   <= 1'b0;
        rep_r  <= 1'b0;
        data_r <= 1'b0;
      end else begin
        if (cmd.set_ok) ok_r <= 1'b1;
        if (cmd.set_rep) rep_r <= 1'b1;
        if (cmd.set_data) data_r <= 1'b1;
      end
    end
  end

  // result fields
  assign fill_ext     = XW'(fill_r);
  assign res_count    = fill_ext[COUNT_W-1:0];
  assign res_ok       = ok_r;
  assign res_replaced = rep_r;
  assign res_priority = data_r ? best_pri_r  : '0;
  assign res_time     = data_r ? best_time_r : '0;
  assign res_payload  = data_r ? best_pay_r  : '0;

endmodule

`default_nettype wire

FILE: sim/bounded_priority_message_queue_checker.sv
// ---------------------------------------------------------------------------
// bounded_priority_message_queue_checker
// Watches the command and result ports of the priority message queue, keeps
// its own copy of the store, predicts every result and compares it with the
// one that comes back, field by field and in order.
// ---------------------------------------------------------------------------
module bounded_priority_message_queue_checker #(
  parameter int DEPTH = bpmq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [bpmq_pkg::OP_W-1:0]     in_op,
  input  wire logic [bpmq_pkg::PRI_W-1:0]    in_new_priority,
  input  wire logic [bpmq_pkg::TIME_W-1:0]   in_new_time,
  input  wire logic [bpmq_pkg::PAY_W-1:0]    in_new_payload,
  input  wire logic                          out_valid,
  input  wire logic                          out_ok,
  input  wire logic                          out_replaced,
  input  wire logic [bpmq_pkg::PRI_W-1:0]    out_priority,
  input  wire logic [bpmq_pkg::TIME_W-1:0]   out_time,
  input  wire logic [bpmq_pkg::PAY_W-1:0]    out_payload,
  input  wire logic [bpmq_pkg::COUNT_W-1:0]  out_count,
  output int unsigned                        replies_pending,
  output int unsigned                        mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bpmq_pkg::*;

  // one predicted result
  typedef struct packed {
    logic               ok;
    logic               replaced;
    logic [PRI_W-1:0]   pri;
    logic [TIME_W-1:0]  stamp;
    logic [PAY_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
  } reply_t;

  // shadow copy of the store
  logic [PRI_W-1:0]  slot_pri   [DEPTH];
  logic [TIME_W-1:0] slot_stamp [DEPTH];
  logic [PAY_W-1:0]  slot_tag   [DEPTH];
  int unsigned       stored = 0;

  reply_t replies_due[$];

  initial begin
    replies_pending = 0;
    mismatch_count  = 0;
  end

  // lower priority ranks below; on equal priority the older stamp ranks below
  function automatic logic ranks_below(input int unsigned a, input int unsigned b);
    if (slot_pri[a] != slot_pri[b]) return slot_pri[a] < slot_pri[b];
    return slot_stamp[a] < slot_stamp[b];
  endfunction

  // first index wins exact ties in both scans
  function automatic int unsigned pick_greatest();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < stored; i++)
      if (ranks_below(best, i)) best = i;
    return best;
  endfunction

  function automatic int unsigned pick_least();
    int unsigned worst;
    worst = 0;
    for (int unsigned i = 1; i < stored; i++)
      if (ranks_below(i, worst)) worst = i;
    return worst;
  endfunction

  // update the shadow store for one item and return the result it should give
  function automatic reply_t apply_queue_op(input op_t op, input logic [PRI_W-1:0] pri,
                                            input logic [TIME_W-1:0] stamp,
                                            input logic [PAY_W-1:0] tag);
    reply_t      r;
    int unsigned slot;
    int unsigned last;
    logic        do_write;
    r = '0;
    case (op)
      OP_PUSH, OP_PUSH_OVER: begin
        do_write = 1'b1;
        slot     = stored;
        if (stored < DEPTH) begin
          stored++;
        end else if (op == OP_PUSH_OVER) begin
          // full store: overwrite the least entry unconditionally
          slot       = pick_least();
          r.replaced = 1'b1;
        end else begin
          do_write = 1'b0;
        end
        r.ok = do_write;
        if (do_write) begin
          slot_pri[slot]   = pri;
          slot_stamp[slot] = stamp;
          slot_tag[slot]   = tag;
        end
      end
      default: begin
        if (stored > 0) begin
          slot    = pick_greatest();
          r.ok    = 1'b1;
          r.pri   = slot_pri[slot];
          r.stamp = slot_stamp[slot];
          r.tag   = slot_tag[slot];
          // pop fills the hole with the last entry
          if (op == OP_POP) begin
            last             = stored - 1;
            slot_pri[slot]   = slot_pri[last];
            slot_stamp[slot] = slot_stamp[last];
            slot_tag[slot]   = slot_tag[last];
            stored           = last;
          end
        end
      end
    endcase
    r.count = COUNT_W'(stored);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // results are checked before the item accepted at the same edge is predicted
  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      stored = 0;
      replies_due.delete();
      replies_pending <= 0;
    end else begin
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result strobe with no item outstanding");
        end else begin
          want = replies_due.pop_front();
          compare_field("ok", 32'(out_ok), 32'(want.ok));
          compare_field("replaced", 32'(out_replaced), 32'(want.replaced));
          compare_field("priority", 32'(out_priority), 32'(want.pri));
          compare_field("time", out_time, want.stamp);
          compare_field("payload", out_payload, want.tag);
          compare_field("count", 32'(out_count), 32'(want.count));
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_queue_op(op_t'(in_op), in_new_priority, in_new_time,
                                             in_new_payload));
      replies_pending <= replies_due.size();
    end
  end

endmodule

FILE: sim/bounded_priority_message_queue_tb.sv
// ---------------------------------------------------------------------------
// bounded_priority_message_queue_tb
// Drives push, push-over, pop and peek items into the priority message queue:
// a directed opening on empty, tied and full stores, then random traffic in
// three idling phases. A separate checker predicts and compares the results.
// ---------------------------------------------------------------------------
module bounded_priority_message_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpmq_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 410;
  localparam int unsigned MODE_RUN        = 30;
  localparam int unsigned TAIL_CYCLES     = 30;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    in_op;
  logic [PRI_W-1:0]   in_new_priority;
  logic [TIME_W-1:0]  in_new_time;
  logic [PAY_W-1:0]   in_new_payload;
  logic               out_valid;
  logic               out_ok;
  logic               out_replaced;
  logic [PRI_W-1:0]   out_priority;
  logic [TIME_W-1:0]  out_time;
  logic [PAY_W-1:0]   out_payload;
  logic [COUNT_W-1:0] out_count;

  int unsigned replies_pending;
  int unsigned mismatch_count;
  int unsigned idle_pct;
  int unsigned quiet_cycles = 0;
  int unsigned sent_by_op [4] = '{default: 0};

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_priority_message_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_new_priority (in_new_priority),
    .in_new_time     (in_new_time),
    .in_new_payload  (in_new_payload),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_replaced    (out_replaced),
    .out_priority    (out_priority),
    .out_time        (out_time),
    .out_payload     (out_payload),
    .out_count       (out_count)
  );

  bounded_priority_message_queue_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_new_priority (in_new_priority),
    .in_new_time     (in_new_time),
    .in_new_payload  (in_new_payload),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_replaced    (out_replaced),
    .out_priority    (out_priority),
    .out_time        (out_time),
    .out_payload     (out_payload),
    .out_count       (out_count),
    .replies_pending (replies_pending),
    .mismatch_count  (mismatch_count)
  );

  // watchdog on cycles with neither an accepted item nor a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one item, with random idle cycles ahead of it, and wait for acceptance
  task automatic issue(input op_t op, input logic [PRI_W-1:0] pri,
                       input logic [TIME_W-1:0] stamp, input logic [PAY_W-1:0] tag);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_new_priority <= pri;
    in_new_time     <= stamp;
    in_new_payload  <= tag;
    do @(posedge clk); while (busy);
    sent_by_op[op]++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (replies_pending != 0);
  endtask

  // biased toward a few values so ties are common, with extremes and full range
  function automatic logic [PRI_W-1:0] draw_priority();
    case ($urandom_range(3))
      0:       return PRI_W'($urandom_range(3));
      1:       return ($urandom_range(1) != 0) ? '1 : '0;
      default: return PRI_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] draw_stamp();
    case ($urandom_range(3))
      0:       return TIME_W'($urandom_range(7));
      1:       return ($urandom_range(1) != 0) ? '1 : '0;
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // fill-heavy, drain-heavy and even runs so the store swings between empty and full
  function automatic op_t draw_op(input int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mode)
      0:       return (roll < 45) ? OP_PUSH : (roll < 80) ? OP_PUSH_OVER :
                      (roll < 92) ? OP_POP : OP_PEEK;
      1:       return (roll < 15) ? OP_PUSH : (roll < 25) ? OP_PUSH_OVER :
                      (roll < 80) ? OP_POP : OP_PEEK;
      default: return op_t'($urandom_range(3));
    endcase
  endfunction

  task automatic run_phase(input int unsigned pct, input int unsigned items);
    int unsigned mode;
    idle_pct = pct;
    mode     = 0;
    for (int unsigned n = 0; n < items; n++) begin
      if (n % MODE_RUN == 0) mode = $urandom_range(2);
      // occasional full drain in mid traffic
      if ($urandom_range(99) < 2) drain();
      issue(draw_op(mode), draw_priority(), draw_stamp(), PAY_W'($urandom));
    end
    drain();
  endtask

  // stimulus
  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_PUSH;
    in_new_priority = '0;
    in_new_time     = '0;
    in_new_payload  = '0;
    idle_pct        = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty store, extremes and exact ties on both ends
    issue(OP_POP, '1, '1, '1);
    issue(OP_PEEK, '1, '1, '1);
    issue(OP_PUSH, '0, '0, '0);
    issue(OP_PUSH, '1, '1, '1);
    issue(OP_PUSH, '1, '1, 32'h5a5a_5a5a);
    issue(OP_PUSH, '0, '0, 32'ha5a5_a5a5);
    issue(OP_PUSH, '1, 32'hffff_fffe, 32'h0000_0001);
    issue(OP_PEEK, '0, '0, '0);
    issue(OP_POP, '0, '0, '0);
    issue(OP_PEEK, '0, '0, '0);
    // push-over below capacity fills the store
    for (int i = 0; i < 12; i++)
      issue(OP_PUSH_OVER, PRI_W'($urandom_range(254, 1)), TIME_W'($urandom),
            PAY_W'($urandom));
    // full store: plain push refused, push-over replaces the least entry
    issue(OP_PUSH, 8'h80, 32'h1234_5678, 32'hdead_beef);
    issue(OP_PUSH_OVER, 8'h80, 32'h1234_5678, 32'hcafe_f00d);
    issue(OP_POP, '0, '0, '0);
    issue(OP_PEEK, '0, '0, '0);
    drain();

    // random traffic under three idling regimes
    run_phase(7, ITEMS_PER_PHASE);
    run_phase(70, ITEMS_PER_PHASE);
    run_phase(0, ITEMS_PER_PHASE);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items: push %0d, push-over %0d, pop %0d, peek %0d",
             sent_by_op[OP_PUSH] + sent_by_op[OP_PUSH_OVER] + sent_by_op[OP_POP] +
             sent_by_op[OP_PEEK], sent_by_op[OP_PUSH], sent_by_op[OP_PUSH_OVER],
             sent_by_op[OP_POP], sent_by_op[OP_PEEK]);
    $display("sender idle at 7%%, 70%% and 0%% of cycles, %0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bpmq_pkg.sv
src/bpmq_ram.sv
src/bpmq_ctrl.sv
src/bpmq_dp.sv
src/bounded_priority_message_queue.sv
sim/bounded_priority_message_queue_checker.sv
sim/bounded_priority_message_queue_tb.sv
